/* rtl/stxp_pkg.sv */
`default_nettype none

package stxp_pkg;

	// framing bytes (ACK 0x06 is implied by frame_done, no transmit side here)
	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_ETX = 8'h03;

	// reset value of max_payload
	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

	// parse phase codes
	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_CHK  = 3'd3;
	localparam logic [2:0] PH_ETX  = 3'd4;

	// error kinds
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_LENGTH   = 2'd1;
	localparam logic [1:0] ERR_CHECKSUM = 2'd2;
	localparam logic [1:0] ERR_ETX      = 2'd3;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] exp_len;
		logic [7:0] run_xor;
		logic [7:0] byte_cnt;
	} parse_state_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_done;
		logic [7:0] frame_length;
		logic       frame_error;
		logic [1:0] error_kind;
	} parse_result_t;

endpackage

`default_nettype wire

/* rtl/stxp_step.sv */
`default_nettype none

module stxp_step
	import stxp_pkg::*;
(
	input  wire parse_state_t  cur,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [7:0]    max_payload,
	output parse_state_t       nxt,
	output parse_result_t      res
);

	logic [7:0] cnt_inc;

	assign cnt_inc = cur.byte_cnt + 8'd1;

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_WAIT: begin
				if (rx_byte == BYTE_STX) begin
					nxt.run_xor  = '0;
					nxt.byte_cnt = '0;
					nxt.phase    = PH_LEN;
				end
			end
			PH_LEN: begin
				nxt.exp_len = rx_byte;
				nxt.run_xor = cur.run_xor ^ rx_byte;
				if (rx_byte > max_payload) begin
					res.frame_error = 1'b1;
					res.error_kind  = ERR_LENGTH;
					nxt.phase       = PH_WAIT;
				end else if (rx_byte == 8'd0) begin
					nxt.phase = PH_CHK;
				end else begin
					nxt.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = cur.byte_cnt;
				nxt.run_xor       = cur.run_xor ^ rx_byte;
				nxt.byte_cnt      = cnt_inc;
				if (cnt_inc >= cur.exp_len) begin
					nxt.phase = PH_CHK;
				end
			end
			PH_CHK: begin
				if (rx_byte != cur.run_xor) begin
					res.frame_error = 1'b1;
					res.error_kind  = ERR_CHECKSUM;
					nxt.phase       = PH_WAIT;
				end else begin
					nxt.phase = PH_ETX;
				end
			end
			PH_ETX: begin
				// whatever sits here is consumed, a stray STX does not restart
				if (rx_byte == BYTE_ETX) begin
					res.frame_done   = 1'b1;
					res.frame_length = cur.exp_len;
				end else begin
					res.frame_error = 1'b1;
					res.error_kind  = ERR_ETX;
				end
				nxt.phase = PH_WAIT;
			end
			default: begin
				nxt.phase = PH_WAIT;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/stx_etx_frame_parser_core.sv */
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-----------------------------------------
// input     | in        | in_valid / in_ready   | rx_byte
// result    | out       | out_valid / out_ready | payload_valid, payload_byte,
//           |           |                      | payload_index, frame_done, frame_length,
//           |           |                      | frame_error, error_kind
// config    | in        | cfg_valid / cfg_ready | cfg_data (max_payload)
//
// one byte per cycle sustained while out_ready is high
// stage 1 holds the received byte, the parse step and the state update sit between
// stage 1 and the result register
// arst_n clears the parse state, the stage valids and sets max_payload to 255
// out_ready low holds the result register; stage 1 still fills, then in_ready drops
// cfg_ready is always high

module stx_etx_frame_parser_core
	import stxp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	// received bytes
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	// results
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            payload_valid,
	output logic [7:0]      payload_byte,
	output logic [7:0]      payload_index,
	output logic            frame_done,
	output logic [7:0]      frame_length,
	output logic            frame_error,
	output logic [1:0]      error_kind
);

	// configuration register
	logic [7:0] max_payload_q;

	// stage 1: captured input byte
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state, updated when the stage 1 byte moves into the result register
	parse_state_t state_q;
	parse_state_t state_nxt;

	// result register
	logic          valid_s2;
	parse_result_t res_s2;
	parse_result_t step_res;

	logic advance_s1;
	logic out_free;

	assign cfg_ready  = 1'b1;
	assign out_free   = !valid_s2 || out_ready;
	assign advance_s1 = valid_s1 && out_free;
	// stage 1 can take a byte when empty or when its byte leaves this cycle
	assign in_ready   = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	stxp_step u_step (
		.cur         (state_q),
		.rx_byte     (byte_s1),
		.max_payload (max_payload_q),
		.nxt         (state_nxt),
		.res         (step_res)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// parse state advances once per byte that reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_WAIT, exp_len: 8'd0, run_xor: 8'd0, byte_cnt: 8'd0};
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_done    = res_s2.frame_done;
	assign frame_length  = res_s2.frame_length;
	assign frame_error   = res_s2.frame_error;
	assign error_kind    = res_s2.error_kind;

`ifndef SYNTHESIS
	// a frame ends either good or rejected, never both
	a_done_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.frame_done && res_s2.frame_error))
		else $error("frame_done and frame_error together");

	// error kind is set exactly when the frame is rejected
	a_kind_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.frame_error == (res_s2.error_kind != ERR_NONE)))
		else $error("error_kind does not match frame_error");

	// every frame outcome puts the parser back to hunting for STX
	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && (step_res.frame_done || step_res.frame_error))
		|=> (state_q.phase == PH_WAIT))
		else $error("parser did not resync after frame end");

	// inside the payload the count never reaches the length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_DATA) |-> (state_q.byte_cnt < state_q.exp_len))
		else $error("payload count overran frame length");

	// parse state only moves with a byte leaving stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance_s1 |=> $stable(state_q))
		else $error("parse state changed without a byte");
`endif

endmodule

`default_nettype wire
